// ===== design/bcle_pkg.sv =====
// Shared types, constants and helpers for the bounded circular list engine.
// Used by the controller, the datapath and the top level; depends on nothing.
package bcle_pkg;

	localparam int CAPACITY = 16;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;

	typedef enum logic [1:0] {
		OP_ADD_FRONT = 2'd0,
		OP_ADD_BACK  = 2'd1,
		OP_SEARCH    = 2'd2,
		OP_REMOVE    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_ADD,
		S_SCAN,
		S_DONE
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;
		logic do_add;
		logic scan_start;
		logic scan;
		logic load_out;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_add;
		logic refused;
		logic scan_done;
		logic out_free;
	} dp_status_t;

	// Physical slot of the entry at a given offset from the head.
	function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] head,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(head) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(CAPACITY)) begin
			sum = sum - (CNT_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage

// ===== design/bounded_circular_list_engine_top.sv =====
// An add passes through decode and the add state to done; a search or remove walks the held
// entries through the single comparator, one held entry per cycle; a full list for an add or
// an empty list for a search or remove goes from decode straight to done.
// One transaction at a time: the next is accepted the cycle after the result is loaded, even
// while that result is still stalled. Reset clears head, count and control; store contents
// are undefined, no clearing pass. Top level; uses bcle_pkg, bcle_ctrl and bcle_dp.
module bounded_circular_list_engine_top import bcle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic                     found,
	output logic [CNT_W-1:0]         removed_count,
	output logic [CNT_W-1:0]         count
);

	cmd_t       cmd;
	dp_status_t st;

	bcle_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	bcle_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.op            (op),
		.value         (value),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found         (found),
		.removed_count (removed_count),
		.count         (count)
	);

endmodule

// ===== design/bcle_ctrl.sv =====
// Controller state machine of the bounded circular list engine.
// Depends on bcle_pkg; drives commands to bcle_dp and the input stall.
module bcle_ctrl import bcle_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  dp_status_t st,
	output cmd_t       cmd
);

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				if (st.refused) begin
					state_d = S_DONE;
				end else if (st.is_add) begin
					state_d = S_ADD;
				end else begin
					state_d = S_SCAN;
				end
			end
			S_ADD: begin
				state_d = S_DONE;
			end
			S_SCAN: begin
				if (st.scan_done) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_stall = 1'b1;
		case (state_q)
			S_IDLE: begin
				in_stall   = 1'b0;
				cmd.accept = in_valid;
			end
			S_DECODE: begin
				cmd.scan_start = !st.refused && !st.is_add;
			end
			S_ADD: begin
				cmd.do_add = 1'b1;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_DONE: begin
				cmd.load_out = st.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

endmodule

// ===== design/bcle_dp.sv =====
// Datapath of the bounded circular list engine: entry store, head and count,
// the single comparator walk and the result register. Depends on bcle_pkg.
module bcle_dp import bcle_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  cmd_t                     cmd,
	output dp_status_t               st,
	input  logic [1:0]               op,
	input  logic signed [DATA_W-1:0] value,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic [1:0]               status,
	output logic                     found,
	output logic [CNT_W-1:0]         removed_count,
	output logic [CNT_W-1:0]         count
);

	logic [DATA_W-1:0] mem [CAPACITY];

	op_t               op_q;
	logic [DATA_W-1:0] val_q;
	status_t           res_q;
	logic [IDX_W-1:0]  head_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  rd_idx_q;
	logic [CNT_W-1:0]  kept_q;
	logic              found_q;
	logic              cmp_vld_s1;
	logic [DATA_W-1:0] rd_data_s1;

	logic              out_vld_q;
	status_t           out_status_q;
	logic              out_found_q;
	logic [CNT_W-1:0]  out_removed_q;
	logic [CNT_W-1:0]  out_count_q;

	op_t               in_op;
	status_t           in_res;
	logic              issue;
	logic              match;
	logic [IDX_W-1:0]  front_head;
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic              is_remove_ok;
	logic [CNT_W-1:0]  new_count;
	logic [CNT_W-1:0]  removed;

	assign in_op = op_t'(op);

	always_comb begin
		in_res = ST_OK;
		if (in_op == OP_ADD_FRONT || in_op == OP_ADD_BACK) begin
			if (count_q >= CNT_W'(CAPACITY)) begin
				in_res = ST_FULL;
			end
		end else if (count_q == '0) begin
			in_res = ST_EMPTY;
		end
	end

	assign issue      = cmd.scan && (rd_idx_q < count_q);
	assign match      = (rd_data_s1 == val_q);
	assign front_head = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;

	// One write port: an add writes the new entry, a remove writes back survivors
	// behind the read pointer, which never overtakes it.
	always_comb begin
		we    = 1'b0;
		waddr = slot_of(head_q, kept_q);
		wdata = rd_data_s1;
		if (cmd.do_add) begin
			we    = 1'b1;
			wdata = val_q;
			waddr = (op_q == OP_ADD_FRONT) ? front_head : slot_of(head_q, count_q);
		end else if (cmp_vld_s1 && !match && op_q == OP_REMOVE) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (issue) begin
			rd_data_s1 <= mem[slot_of(head_q, rd_idx_q[CNT_W-1:0])];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			val_q <= value;
		end
	end

	always_comb begin
		is_remove_ok = (op_q == OP_REMOVE) && (res_q == ST_OK);
		new_count    = is_remove_ok ? kept_q : count_q;
		removed      = is_remove_ok ? count_q - kept_q : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q          <= OP_ADD_FRONT;
			res_q         <= ST_OK;
			head_q        <= '0;
			count_q       <= '0;
			rd_idx_q      <= '0;
			kept_q        <= '0;
			found_q       <= 1'b0;
			cmp_vld_s1    <= 1'b0;
			out_vld_q     <= 1'b0;
			out_status_q  <= ST_OK;
			out_found_q   <= 1'b0;
			out_removed_q <= '0;
			out_count_q   <= '0;
		end else begin
			if (cmd.accept) begin
				op_q    <= in_op;
				res_q   <= in_res;
				found_q <= 1'b0;
			end
			if (cmd.do_add) begin
				count_q <= count_q + 1'b1;
				if (op_q == OP_ADD_FRONT) begin
					head_q <= front_head;
				end
			end
			if (cmd.scan_start) begin
				rd_idx_q   <= '0;
				kept_q     <= '0;
				cmp_vld_s1 <= 1'b0;
			end else begin
				cmp_vld_s1 <= issue;
				if (issue) begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
				if (cmp_vld_s1) begin
					if (match) begin
						if (op_q == OP_SEARCH) begin
							found_q <= 1'b1;
						end
					end else begin
						kept_q <= kept_q + 1'b1;
					end
				end
			end
			if (cmd.load_out) begin
				count_q       <= new_count;
				out_vld_q     <= 1'b1;
				out_status_q  <= res_q;
				out_found_q   <= found_q;
				out_removed_q <= removed;
				out_count_q   <= new_count;
			end else if (!out_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign st.is_add    = (op_q == OP_ADD_FRONT) || (op_q == OP_ADD_BACK);
	assign st.refused   = (res_q != ST_OK);
	assign st.scan_done = !issue;
	assign st.out_free  = !out_vld_q || !out_stall;

	assign out_valid     = out_vld_q;
	assign status        = out_status_q;
	assign found         = out_found_q;
	assign removed_count = out_removed_q;
	assign count         = out_count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_kept_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		kept_q <= rd_idx_q)
		else $error("compaction write pointer overtook read pointer");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan |-> (rd_idx_q <= count_q))
		else $error("scan read index ran past the held entries");

	a_found_search_only: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> (op_q == OP_SEARCH))
		else $error("found flag set by a request other than search");

endmodule
